// ===== rtl/resource_profile_earliest_start_defines.svh =====
// ----------------------------------------------------------------------------
// Resource profile assertion macros
// Shared property forms used by the block's assertions.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_PROFILE_EARLIEST_START_DEFINES_SVH
`define RESOURCE_PROFILE_EARLIEST_START_DEFINES_SVH

// same-cycle implication
`define RPES_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define RPES_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/rpes_pkg.sv =====
// ----------------------------------------------------------------------------
// rpes_pkg
// Types and constants of the resource profile earliest-start block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rpes_pkg;
    localparam int MAX_RESOURCES_DEF = 4;
    localparam int MAX_SLOTS_DEF     = 1024;
    localparam int NEED_FIELDS       = 4;
    localparam int TW                = 12;   // slot counter width
    localparam int FW                = 11;   // time field width
    localparam int LW                = 16;   // load width

    localparam logic [2:0] REG_RES_IN_USE = 3'd0;
    localparam logic [2:0] REG_HORIZON    = 3'd1;
    localparam logic [2:0] REG_CAP_0      = 3'd2;
    localparam logic [2:0] REG_CAP_1      = 3'd3;
    localparam logic [2:0] REG_CAP_2      = 3'd4;
    localparam logic [2:0] REG_CAP_3      = 3'd5;

    typedef struct packed {
        logic          op;
        logic [FW-1:0] start_time;
        logic [FW-1:0] duration;
        logic [FW-1:0] stop_time;
        logic [LW-1:0] need_0;
        logic [LW-1:0] need_1;
        logic [LW-1:0] need_2;
        logic [LW-1:0] need_3;
    } t_in_item;

    typedef struct packed {
        logic [FW-1:0] earliest_start;
        logic          found;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_SKIP   = 2'd0,
        CMD_RESULT = 2'd1,
        CMD_SCAN   = 2'd2,
        CMD_ADD    = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                         kind;
        logic [FW-1:0]                     start;
        logic [FW-1:0]                     dur;
        logic [FW-1:0]                     lim;
        logic [NEED_FIELDS-1:0][LW-1:0]    need;
    } t_cmd;

    typedef struct packed {
        logic [2:0]                        active;
        logic [FW-1:0]                     horizon;
        logic [NEED_FIELDS-1:0][LW-1:0]    cap;
    } t_cfg;
endpackage

// ===== rtl/rpes_ram.sv =====
// ----------------------------------------------------------------------------
// rpes_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rpes_front.sv =====
// ----------------------------------------------------------------------------
// rpes_front
// Accepts items, classifies them into commands, two-entry command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpes_front #(
    parameter int MAX_RESOURCES = rpes_pkg::MAX_RESOURCES_DEF,
    parameter int MAX_SLOTS     = rpes_pkg::MAX_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpes_pkg::t_cfg    i_cfg,
    input  logic              i_clearing,
    input  logic              i_push,
    input  rpes_pkg::t_in_item i_in,
    output logic              o_full,
    output logic              o_cmd_valid,
    output rpes_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import rpes_pkg::*;

    localparam logic [16:0] SLOTS = 17'(MAX_SLOTS);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       s_acc, s_pop;
    t_cmd       s_cmd;
    logic [FW-1:0] s_end, s_stop;

    always_comb begin
        s_end  = ({6'd0, i_cfg.horizon} > SLOTS) ? FW'(MAX_SLOTS) : i_cfg.horizon;
        s_stop = ({6'd0, i_in.stop_time} > SLOTS) ? FW'(MAX_SLOTS) : i_in.stop_time;
        s_cmd.start = i_in.start_time;
        s_cmd.dur   = i_in.duration;
        s_cmd.need  = {i_in.need_3, i_in.need_2, i_in.need_1, i_in.need_0};
        if (!i_in.op) begin
            s_cmd.lim  = s_end;
            s_cmd.kind = (i_in.duration == '0 || i_in.start_time >= s_end)
                         ? CMD_RESULT : CMD_SCAN;
        end else begin
            s_cmd.lim  = s_stop;
            s_cmd.kind = (i_in.start_time < s_stop && i_cfg.active != '0)
                         ? CMD_ADD : CMD_SKIP;
        end
    end

    assign o_full      = (r_cnt == 2'd2) || i_clearing;
    assign s_acc       = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign s_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_q[r_wp] <= s_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (s_acc) begin
                r_wp <= ~r_wp;
            end
            if (s_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(s_acc) - 2'(s_pop);
        end
    end
endmodule

// ===== rtl/rpes_engine.sv =====
// ----------------------------------------------------------------------------
// rpes_engine
// Executes commands over the load memories; holds the result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpes_engine #(
    parameter int MAX_RESOURCES = rpes_pkg::MAX_RESOURCES_DEF,
    parameter int MAX_SLOTS     = rpes_pkg::MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rpes_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    input  rpes_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_clearing,
    output logic                o_empty,
    output rpes_pkg::t_out_item o_out,
    input  logic                i_pop
);
    import rpes_pkg::*;

    localparam int LANES = (MAX_RESOURCES < NEED_FIELDS) ? MAX_RESOURCES : NEED_FIELDS;
    localparam int AW    = $clog2(MAX_SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_ADD   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [AW-1:0]   r_clr;
    logic [TW-1:0]   r_it, n_it;
    logic [TW-1:0]   r_et;
    logic            r_ev, n_ev;
    logic [TW-1:0]   r_run, n_run;

    t_out_item       r_rq [2];
    logic            r_rwp, r_rrp;
    logic [1:0]      r_rcnt;
    logic            s_rpush, s_rpop;
    t_out_item       s_res;

    logic            s_issue, s_ok, s_done;
    logic [TW-1:0]   s_et1, s_run1, s_lim;
    logic [LANES-1:0] s_lane_ok;
    logic [LANES-1:0][LW-1:0] s_rdata, s_wdata;
    logic            s_we;
    logic [AW-1:0]   s_waddr, s_raddr;

    assign s_lim   = TW'(r_cmd.lim);
    assign s_et1   = r_et + TW'(1);
    assign s_raddr = AW'(r_it);
    assign s_we    = (r_state == S_CLEAR) || ((r_state == S_ADD) && r_ev);
    assign s_waddr = (r_state == S_CLEAR) ? r_clr : AW'(r_et);

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [LW:0]   s_sum;
        logic [LW-1:0] s_rem;
        logic          s_act;

        assign s_act = (3'(l) < i_cfg.active);
        assign s_sum = {1'b0, s_rdata[l]} + {1'b0, r_cmd.need[l]};
        assign s_wdata[l] = (r_state == S_CLEAR) ? '0 :
                            (!s_act ? s_rdata[l] :
                             (s_sum[LW] ? {LW{1'b1}} : s_sum[LW-1:0]));
        assign s_rem = (i_cfg.cap[l] > s_rdata[l]) ? i_cfg.cap[l] - s_rdata[l] : '0;
        assign s_lane_ok[l] = !s_act || (s_rem >= r_cmd.need[l]);

        rpes_ram #(.WIDTH(LW), .DEPTH(MAX_SLOTS)) u_ram (
            .i_clk   (i_clk),
            .i_we    (s_we),
            .i_waddr (s_waddr),
            .i_wdata (s_wdata[l]),
            .i_raddr (s_raddr),
            .o_rdata (s_rdata[l])
        );
    end

    assign s_ok   = &s_lane_ok;
    assign s_run1 = s_ok ? r_run + TW'(1) : '0;

    always_comb begin
        n_state   = r_state;
        n_it      = r_it;
        n_ev      = 1'b0;
        n_run     = r_run;
        o_cmd_pop = 1'b0;
        s_rpush   = 1'b0;
        s_res     = '0;
        s_issue   = 1'b0;
        s_done    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_it  = TW'(i_cmd.start);
                n_run = '0;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        CMD_SKIP: o_cmd_pop = 1'b1;
                        CMD_ADD: begin
                            o_cmd_pop = 1'b1;
                            n_state   = S_ADD;
                        end
                        CMD_RESULT: begin
                            if (r_rcnt != 2'd2) begin
                                o_cmd_pop = 1'b1;
                                s_rpush   = 1'b1;
                                s_res.earliest_start = i_cmd.start;
                                s_res.found = (i_cmd.dur == '0);
                            end
                        end
                        CMD_SCAN: begin
                            if (r_rcnt != 2'd2) begin
                                o_cmd_pop = 1'b1;
                                n_state   = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                s_issue = (r_it < s_lim);
                if (r_ev) begin
                    n_run  = s_run1;
                    s_done = (s_run1 >= TW'(r_cmd.dur)) || (s_et1 >= s_lim);
                end
                if (s_done) begin
                    s_rpush = 1'b1;
                    s_res.earliest_start = FW'(s_et1 - s_run1);
                    s_res.found = (s_run1 >= TW'(r_cmd.dur));
                    n_state = S_IDLE;
                end else begin
                    n_ev = s_issue;
                    if (s_issue) begin
                        n_it = r_it + TW'(1);
                    end
                end
            end
            S_ADD: begin
                s_issue = (r_it < s_lim);
                s_done  = r_ev && (s_et1 >= s_lim);
                if (s_done) begin
                    n_state = S_IDLE;
                end else begin
                    n_ev = s_issue;
                    if (s_issue) begin
                        n_it = r_it + TW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign s_rpop     = i_pop && !o_empty;
    assign o_empty    = (r_rcnt == 2'd0);
    assign o_out      = r_rq[r_rrp];
    assign o_clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        r_it  <= n_it;
        r_et  <= r_it;
        r_run <= n_run;
        if (r_state == S_IDLE && o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (s_rpush) begin
            r_rq[r_rwp] <= s_res;
        end
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ev    <= 1'b0;
            r_rwp   <= 1'b0;
            r_rrp   <= 1'b0;
            r_rcnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_ev    <= n_ev;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (s_rpush) begin
                r_rwp <= ~r_rwp;
            end
            if (s_rpop) begin
                r_rrp <= ~r_rrp;
            end
            r_rcnt <= r_rcnt + 2'(s_rpush) - 2'(s_rpop);
        end
    end
endmodule

// ===== rtl/resource_profile_earliest_start.sv =====
// ----------------------------------------------------------------------------
// resource_profile_earliest_start
// Time-indexed resource profile with earliest-start window search.
// ----------------------------------------------------------------------------
// Input items arrive through a queue port (i_push / o_full); each item is a
// query (op 0) or an add (op 1). Query results leave through a queue port
// (o_empty / i_pop); adds give no result. Registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce. The load table is
// one RAM per resource, read one slot per cycle. A query scans one slot per
// cycle, all resources checked in parallel, behind the registered RAM read.
// An add runs as a pipelined read-modify-write per slot. Trivial queries
// (zero duration, start at or past horizon) give their result from idle
// without a scan, and empty adds are dropped. Up to two commands queue ahead
// of the engine and two results behind it; a stalled receiver stops new
// queries from starting once the result queue is full, while adds at the
// head of the command queue still run. After reset a clearing pass writes
// zero to all MAX_SLOTS slots (1024 by default), during which o_full stays high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "resource_profile_earliest_start_defines.svh"
module resource_profile_earliest_start #(
    parameter int MAX_RESOURCES = rpes_pkg::MAX_RESOURCES_DEF,
    parameter int MAX_SLOTS     = rpes_pkg::MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rpes_pkg::t_in_item  i_in,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output rpes_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_wdata
);
    import rpes_pkg::*;

    localparam int LANES = (MAX_RESOURCES < NEED_FIELDS) ? MAX_RESOURCES : NEED_FIELDS;

    logic [2:0]                     r_res_in_use;
    logic [FW-1:0]                  r_horizon;
    logic [NEED_FIELDS-1:0][LW-1:0] r_cap;
    t_cfg   s_cfg;
    logic   s_clearing, s_cmd_valid, s_cmd_pop;
    t_cmd   s_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_in_use <= 3'd4;
            r_horizon    <= FW'(1024);
            r_cap        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RES_IN_USE: r_res_in_use <= i_cfg_wdata[2:0];
                REG_HORIZON:    r_horizon    <= i_cfg_wdata[FW-1:0];
                REG_CAP_0:      r_cap[0]     <= i_cfg_wdata;
                REG_CAP_1:      r_cap[1]     <= i_cfg_wdata;
                REG_CAP_2:      r_cap[2]     <= i_cfg_wdata;
                REG_CAP_3:      r_cap[3]     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        s_cfg.active  = (r_res_in_use > 3'(LANES)) ? 3'(LANES) : r_res_in_use;
        s_cfg.horizon = r_horizon;
        s_cfg.cap     = r_cap;
    end

    rpes_front #(.MAX_RESOURCES(MAX_RESOURCES), .MAX_SLOTS(MAX_SLOTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (s_cfg),
        .i_clearing  (s_clearing),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_cmd_valid (s_cmd_valid),
        .o_cmd       (s_cmd),
        .i_cmd_pop   (s_cmd_pop)
    );

    rpes_engine #(.MAX_RESOURCES(MAX_RESOURCES), .MAX_SLOTS(MAX_SLOTS)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (s_cfg),
        .i_cmd_valid (s_cmd_valid),
        .i_cmd       (s_cmd),
        .o_cmd_pop   (s_cmd_pop),
        .o_clearing  (s_clearing),
        .o_empty     (o_empty),
        .o_out       (o_out),
        .i_pop       (i_pop)
    );

    `RPES_ASSERT_NOW(a_full_in_clear, i_clk, i_rst_n, s_clearing, o_full, "item accepted during clear")
    `RPES_ASSERT_NOW(a_empty_in_clear, i_clk, i_rst_n, s_clearing, o_empty, "result during clear")
    `RPES_ASSERT_NEXT(a_no_pop_in_clear, i_clk, i_rst_n, s_clearing, !$past(s_cmd_pop), "command taken during clear")
endmodule
